/* design/dswa_pkg.sv */
`default_nettype none
package dswa_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_UP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DOWN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_START  = 3'd5;

    localparam logic [7:0] RST_ACCEPT_COUNT = 8'd4;
    localparam logic [7:0] RST_STEP_UP      = 8'd10;
    localparam logic [7:0] RST_STEP_DOWN    = 8'd20;
    localparam logic [7:0] RST_WIDTH_MIN    = 8'd32;
    localparam logic [7:0] RST_WIDTH_MAX    = 8'd152;
    localparam logic [7:0] RST_WIDTH_START  = 8'd95;

    localparam logic [7:0] COUNT_SAT = 8'hFF;

    typedef struct packed {
        logic level_up_n;
        logic level_down_n;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pulse_width;
        logic       up_event;
        logic       down_event;
    } t_out_item;

    typedef struct packed {
        logic [7:0] accept_count;
        logic [7:0] step_up;
        logic [7:0] step_down;
        logic [7:0] width_min;
        logic [7:0] width_max;
        logic [7:0] width_start;
        logic       load_start;
    } t_cfg;

endpackage
`default_nettype wire

/* design/dswa_cfg.sv */
`default_nettype none
module dswa_cfg
    import dswa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire logic [CFG_IDX_W-1:0] i_index,
    input  wire logic [7:0]           i_data,
    output t_cfg                      o_cfg
);

    logic [7:0] r_accept_count;
    logic [7:0] r_step_up;
    logic [7:0] r_step_down;
    logic [7:0] r_width_min;
    logic [7:0] r_width_max;
    logic [7:0] r_width_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_count <= RST_ACCEPT_COUNT;
            r_step_up      <= RST_STEP_UP;
            r_step_down    <= RST_STEP_DOWN;
            r_width_min    <= RST_WIDTH_MIN;
            r_width_max    <= RST_WIDTH_MAX;
            r_width_start  <= RST_WIDTH_START;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_ACCEPT_COUNT: r_accept_count <= i_data;
                CFG_STEP_UP:      r_step_up      <= i_data;
                CFG_STEP_DOWN:    r_step_down    <= i_data;
                CFG_WIDTH_MIN:    r_width_min    <= i_data;
                CFG_WIDTH_MAX:    r_width_max    <= i_data;
                CFG_WIDTH_START:  r_width_start  <= i_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.accept_count = r_accept_count;
        o_cfg.step_up      = r_step_up;
        o_cfg.step_down    = r_step_down;
        o_cfg.width_min    = r_width_min;
        o_cfg.width_max    = r_width_max;
        o_cfg.width_start  = r_width_start;
        // width register follows a width_start write in the same edge
        o_cfg.load_start   = i_wr && (i_index == CFG_WIDTH_START);
    end

endmodule
`default_nettype wire

/* design/dswa_core.sv */
`default_nettype none
module dswa_core
    import dswa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    input  wire logic [7:0] i_cfg_data,
    input  wire t_cfg     i_cfg,
    output t_out_item     o_result
);

    logic [7:0] r_count_up;
    logic [7:0] r_count_down;
    logic       r_acc_up;
    logic       r_acc_down;
    logic [7:0] r_width;

    logic [7:0] n_count_up;
    logic [7:0] n_count_down;
    logic       n_acc_up;
    logic       n_acc_down;
    logic [7:0] n_width;

    logic       up_now;
    logic       dn_now;
    logic       up_ev;
    logic       dn_ev;
    logic [7:0] cnt_inc;
    logic [8:0] sum;
    logic [8:0] diff;

    always_comb begin
        up_now       = !i_item.level_up_n;
        dn_now       = !i_item.level_down_n;
        n_count_up   = r_count_up;
        n_count_down = r_count_down;
        n_acc_up     = r_acc_up;
        n_acc_down   = r_acc_down;
        up_ev        = 1'b0;
        dn_ev        = 1'b0;
        cnt_inc      = '0;

        // up button has priority; down counted only while up is stable
        if (up_now != r_acc_up) begin
            cnt_inc    = (r_count_up == COUNT_SAT) ? r_count_up : r_count_up + 8'd1;
            n_count_up = cnt_inc;
            if (cnt_inc >= i_cfg.accept_count) begin
                n_acc_up = up_now;
                up_ev    = up_now;
            end
        end else if (dn_now != r_acc_down) begin
            cnt_inc      = (r_count_down == COUNT_SAT) ? r_count_down : r_count_down + 8'd1;
            n_count_down = cnt_inc;
            if (cnt_inc >= i_cfg.accept_count) begin
                n_acc_down = dn_now;
                dn_ev      = dn_now;
            end
        end else begin
            n_count_up   = '0;
            n_count_down = '0;
        end

        // clamp without wrap; below min wins over above max
        sum  = {1'b0, r_width} + {1'b0, i_cfg.step_up};
        diff = {1'b0, r_width} - {1'b0, i_cfg.step_down};
        n_width = r_width;
        if (dn_ev) begin
            if (diff[8] || (diff[7:0] < i_cfg.width_min)) begin
                n_width = i_cfg.width_min;
            end else if (diff[7:0] > i_cfg.width_max) begin
                n_width = i_cfg.width_max;
            end else begin
                n_width = diff[7:0];
            end
        end else if (up_ev) begin
            if (sum < {1'b0, i_cfg.width_min}) begin
                n_width = i_cfg.width_min;
            end else if (sum > {1'b0, i_cfg.width_max}) begin
                n_width = i_cfg.width_max;
            end else begin
                n_width = sum[7:0];
            end
        end

        o_result.pulse_width = n_width;
        o_result.up_event    = up_ev;
        o_result.down_event  = dn_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_up   <= '0;
            r_count_down <= '0;
            r_acc_up     <= 1'b0;
            r_acc_down   <= 1'b0;
            r_width      <= RST_WIDTH_START;
        end else if (i_cfg.load_start) begin
            r_width <= i_cfg_data;
        end else if (i_accept) begin
            r_count_up   <= n_count_up;
            r_count_down <= n_count_down;
            r_acc_up     <= n_acc_up;
            r_acc_down   <= n_acc_down;
            r_width      <= n_width;
        end
    end

endmodule
`default_nettype wire

/* design/debounced_step_width_adjust.sv */
// Debounced two-button pulse-width adjuster.
// Input channel: one transaction per debounce tick, carrying the raw active-low
// levels of the up and down buttons (i_in_valid / o_in_stall / i_in_data).
// Output channel: exactly one result transaction per input transaction, in
// order, carrying the updated pulse width and the up/down press events
// (o_out_valid / i_out_stall / o_out_data).
// Configuration channel: i_cfg_valid / o_cfg_ready with a 3-bit register index
// and 8-bit data; ready is always high. Write only while the block is idle.
// Writing width_start also loads the current width.
// The result is registered: it appears in the cycle after its tick is accepted.
// Throughput: one tick per cycle; the debounce and clamp logic is a single
// combinational pass between the state registers and the result register.
// Stall: while a result waits in the result register under i_out_stall, the
// input is stalled; as soon as the result is taken a new tick enters in the
// same cycle, so back-to-back flow is kept.
// Reset (synchronous, active low): counters clear, both buttons read released,
// registers take their defaults, width is 95 and the result register empties.
`default_nettype none
module debounced_step_width_adjust
    import dswa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    t_cfg      cfg;
    t_out_item result;
    logic      in_accept;
    logic      cfg_wr;

    logic      r_out_valid;
    t_out_item r_out_data;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // hold the input while an untaken result blocks the result register
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    dswa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    dswa_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_item     (i_in_data),
        .i_cfg_data (i_cfg_data),
        .i_cfg      (cfg),
        .o_result   (result)
    );

    // result register: load on every accepted tick, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted tick produced no result");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !in_accept) |=> !o_out_valid)
        else $error("result repeated after being taken");

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.up_event && o_out_data.down_event))
        else $error("up and down events in the same tick");

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import dswa_pkg::*;

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int TIMEOUT_NS    = 5_000_000;

    // Indexes past the end of the register map; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_data   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    logic      o_in_stall;
    logic      o_out_valid;
    logic      o_cfg_ready;
    t_out_item o_out_data;

    // Percent of cycles in which the tick source idles and the result sink stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int ticks_sent      = 0;
    int results_checked = 0;
    int up_presses      = 0;
    int down_presses    = 0;
    int mismatches      = 0;

    // Last raw levels handed to the block; the press generator walks from here.
    logic last_up_n   = 1'b1;
    logic last_down_n = 1'b1;

    // Predicted results, oldest first.
    t_out_item expected_results[$];

    // Shadow copy of the register map.
    logic [7:0] accept_thr;
    logic [7:0] step_up_amt;
    logic [7:0] step_down_amt;
    logic [7:0] width_lo;
    logic [7:0] width_hi;
    logic [7:0] width_init;

    // Shadow copy of the debounce and width state.
    logic [7:0] up_count;
    logic [7:0] down_count;
    logic       up_pressed;
    logic       down_pressed;
    logic [7:0] width_now;

    debounced_step_width_adjust uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    function automatic void reset_shadow();
        accept_thr    = RST_ACCEPT_COUNT;
        step_up_amt   = RST_STEP_UP;
        step_down_amt = RST_STEP_DOWN;
        width_lo      = RST_WIDTH_MIN;
        width_hi      = RST_WIDTH_MAX;
        width_init    = RST_WIDTH_START;
        up_count      = '0;
        down_count    = '0;
        up_pressed    = 1'b0;
        down_pressed  = 1'b0;
        width_now     = RST_WIDTH_START;
    endfunction

    function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        case (idx)
            CFG_ACCEPT_COUNT: accept_thr = val;
            CFG_STEP_UP:      step_up_amt = val;
            CFG_STEP_DOWN:    step_down_amt = val;
            CFG_WIDTH_MIN:    width_lo = val;
            CFG_WIDTH_MAX:    width_hi = val;
            CFG_WIDTH_START: begin
                // A new start value also takes effect on the live width.
                width_init = val;
                width_now  = val;
            end
            default: ;
        endcase
    endfunction

    // Min wins below the floor, max wins everywhere else above the ceiling,
    // which also settles the case of crossed limits.
    function automatic logic [7:0] clamp_width(int raw);
        if (raw < int'(width_lo))
            return width_lo;
        if (raw > int'(width_hi))
            return width_hi;
        return raw[7:0];
    endfunction

    function automatic t_out_item debounce_tick(t_in_item item);
        logic      up_now;
        logic      down_now;
        logic      up_ev;
        logic      down_ev;
        t_out_item res;
        up_now   = ~item.level_up_n;
        down_now = ~item.level_down_n;
        up_ev    = 1'b0;
        down_ev  = 1'b0;
        // Up is examined first; down only gets a look while up is settled.
        if (up_now != up_pressed) begin
            if (up_count != COUNT_SAT)
                up_count = up_count + 8'd1;
            if (up_count >= accept_thr) begin
                up_pressed = up_now;
                up_ev      = up_now;
            end
        end else if (down_now != down_pressed) begin
            if (down_count != COUNT_SAT)
                down_count = down_count + 8'd1;
            if (down_count >= accept_thr) begin
                down_pressed = down_now;
                down_ev      = down_now;
            end
        end else begin
            // Counters survive an acceptance and only clear once both settle.
            up_count   = '0;
            down_count = '0;
        end
        if (down_ev)
            width_now = clamp_width(int'(width_now) - int'(step_down_amt));
        else if (up_ev)
            width_now = clamp_width(int'(width_now) + int'(step_up_amt));
        res.pulse_width = width_now;
        res.up_event    = up_ev;
        res.down_event  = down_ev;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Drive one tick transaction; hold valid and data until it is taken.
    // Valid is left high on return so back-to-back ticks keep it asserted.
    task automatic send_tick(input logic up_n, input logic down_n);
        t_in_item  item;
        t_out_item res;
        item.level_up_n   = up_n;
        item.level_down_n = down_n;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        res = debounce_tick(item);
        expected_results.push_back(res);
        last_up_n   = up_n;
        last_down_n = down_n;
        ticks_sent++;
        if (res.up_event)
            up_presses++;
        if (res.down_event)
            down_presses++;
    endtask

    // Drop valid and hold off until every predicted result has come back.
    // It always waits on the clock first, so register writes never share a step
    // with the lowering of the tick valid.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Write one register; the strobe stays high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        store_reg(idx, val);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] thr, input logic [7:0] up_amt,
                              input logic [7:0] down_amt, input logic [7:0] lo,
                              input logic [7:0] hi, input logic [7:0] start);
        wait_idle();
        write_reg(CFG_ACCEPT_COUNT, thr);
        write_reg(CFG_STEP_UP, up_amt);
        write_reg(CFG_STEP_DOWN, down_amt);
        write_reg(CFG_WIDTH_MIN, lo);
        write_reg(CFG_WIDTH_MAX, hi);
        write_reg(CFG_WIDTH_START, start);
        end_writes();
    endtask

    // Mostly ordered limits, now and then a fully random (possibly crossed) pair.
    task automatic load_random_config(input logic [7:0] thr);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'($urandom_range(128));
        hi = 8'($urandom_range(255, int'(lo)));
        if ($urandom_range(4) == 0) begin
            lo = 8'($urandom_range(255));
            hi = 8'($urandom_range(255));
        end
        set_config(thr, 8'($urandom_range(255)), 8'($urandom_range(255)), lo, hi,
                   8'($urandom_range(255)));
    endtask

    // Press generator: mostly clean level changes held long enough to be
    // accepted, some bounces cut short, and some raw noise.
    task automatic run_presses(input int n_ticks);
        int   first;
        int   hold;
        int   pick;
        logic up_n;
        logic down_n;
        first = ticks_sent;
        while (ticks_sent - first < n_ticks) begin
            pick   = $urandom_range(99);
            up_n   = last_up_n;
            down_n = last_down_n;
            if ($urandom_range(1))
                up_n = ~up_n;
            else
                down_n = ~down_n;
            if (pick < 70)
                hold = int'(accept_thr) + $urandom_range(3);
            else if (pick < 85)
                hold = $urandom_range((accept_thr > 8'd1) ? int'(accept_thr) - 1 : 1, 1);
            else
                hold = 0;
            if (hold > 0) begin
                repeat (hold) send_tick(up_n, down_n);
            end else begin
                repeat ($urandom_range(4, 1))
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------

    // Randomly stall the result channel; no stall while in reset.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%t: %s: expected width=%0d up=%0b down=%0b, got width=%0d up=%0b down=%0b",
                     $realtime, what, want.pulse_width, want.up_event, want.down_event,
                     got.pulse_width, got.up_event, got.down_event);
    endtask

    // Compare every taken result with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && out_stall == 1'b0) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, o_out_data);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_out_data.pulse_width !== want.pulse_width ||
                    o_out_data.up_event !== want.up_event ||
                    o_out_data.down_event !== want.down_event)
                    report_mismatch("result differs", want, o_out_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: four ticks to accept, step up 10, step down 20.
    task automatic test_reset_defaults();
        repeat (4) send_tick(1'b0, 1'b1);
        repeat (4) send_tick(1'b0, 1'b0);
    endtask

    // Zero threshold accepts the first differing tick; full-scale up step
    // slams into a full-scale ceiling.
    task automatic test_zero_threshold();
        set_config(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
    endtask

    // Crossed limits with a start value outside them: the width stays put
    // until an event, then min catches the low side and max the rest.
    task automatic test_crossed_limits();
        set_config(8'd1, 8'd255, 8'd255, 8'd200, 8'd100, 8'd150);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
    endtask

    // A counter left at the threshold after acceptance lets the very next
    // change through at once.
    task automatic test_counter_carry();
        wait_idle();
        write_reg(CFG_ACCEPT_COUNT, 8'd3);
        end_writes();
        repeat (3) send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
    endtask

    // Writes past the map are dropped; also load the opposite extremes.
    task automatic test_spare_index();
        wait_idle();
        write_reg(CFG_SPARE_LO, 8'($urandom_range(255)));
        write_reg(CFG_SPARE_HI, 8'($urandom_range(255)));
        write_reg(CFG_STEP_DOWN, 8'd255);
        write_reg(CFG_STEP_UP, 8'd0);
        write_reg(CFG_WIDTH_MIN, 8'd0);
        write_reg(CFG_WIDTH_MAX, 8'd255);
        write_reg(CFG_WIDTH_START, 8'd255);
        end_writes();
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
    endtask

    // Random presses over a few random register settings.
    task automatic test_random_presses(input int n_sets, input int ticks_per_set);
        repeat (n_sets) begin
            load_random_config(8'($urandom_range(8, 1)));
            run_presses(ticks_per_set);
        end
    endtask

    // Alternate single-button toggles never let both buttons settle, so both
    // counters climb past 255 and must saturate.
    task automatic test_counter_saturation();
        load_random_config(8'd1);
        for (int i = 0; i < 520; i++) begin
            if (i % 2 == 0)
                send_tick(~last_up_n, last_down_n);
            else
                send_tick(last_up_n, ~last_down_n);
        end
    endtask

    // Full-scale threshold: only long holds get accepted.
    task automatic test_long_hold();
        load_random_config(8'd255);
        run_presses(200);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------

    initial begin
        reset_shadow();
        send_idle_pct  = 24;
        recv_stall_pct = 72;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_zero_threshold();
        test_crossed_limits();
        test_counter_carry();
        test_spare_index();
        test_random_presses(3, 150);

        // Swap the pressure: slow source, mostly ready sink.
        wait_idle();
        send_idle_pct  = 72;
        recv_stall_pct = 24;
        test_counter_saturation();
        test_long_hold();

        // Full rate on both sides.
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_presses(4, 70);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d ticks, checked %0d results, saw %0d up and %0d down presses",
                 ticks_sent, results_checked, up_presses, down_presses);
        $display("Covered zero and full-scale thresholds, crossed limits, saturation, idle mixes");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop if the handshakes ever lock up.
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout after %0d ticks and %0d results", ticks_sent, results_checked);
        $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
design/dswa_pkg.sv
design/dswa_cfg.sv
design/dswa_core.sv
design/debounced_step_width_adjust.sv
sim/testbench.sv
